FILE: rtl/core/nge_pkg.sv
// nge_pkg: shared constants, types and the microcode ROM of the next greater
// element engine. No dependencies; every other file imports it.
package nge_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int VALUE_BITS  = 10;
  localparam int IO_BITS     = 10;
  localparam int OP_W        = 2;

  localparam int STK_AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int VB_MIN  = (VALUE_BITS < IO_BITS) ? VALUE_BITS : IO_BITS;
  localparam int ANS_DEPTH = 1 << VALUE_BITS;

  typedef logic [VALUE_BITS-1:0] val_t;
  typedef logic [VALUE_BITS:0]   ans_t;   // {valid, answer}
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [IO_BITS-1:0]    io_val_t;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_PUSH  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // sequencer steps
  typedef enum logic [2:0] {
    ST_SWEEP = 3'd0,
    ST_IDLE  = 3'd1,
    ST_CLR   = 3'd2,
    ST_NOP   = 3'd3,
    ST_QOUT  = 3'd4,
    ST_PCMP  = 3'd5,
    ST_PPUSH = 3'd6
  } step_t;

  typedef enum logic [2:0] {
    C_ALWAYS    = 3'd0,
    C_ACCEPT    = 3'd1,
    C_SLOT      = 3'd2,
    C_POP       = 3'd3,
    C_SWEEP_END = 3'd4
  } cond_t;

  typedef enum logic [1:0] {
    RES_NONE  = 2'd0,
    RES_ZERO  = 2'd1,
    RES_QUERY = 2'd2,
    RES_PUSH  = 2'd3
  } res_t;

  typedef struct packed {
    cond_t cond;
    step_t on_true;
    step_t on_false;
    logic  accept;   // in_ready
    logic  sweep;    // clear one answer entry
    logic  cnt_clr;
    logic  stk_rd;   // read top (or entry below top when popping)
    logic  ans_rd;
    logic  pop;
    logic  push;
    res_t  emit;
  } ctl_t;

  typedef struct packed {
    logic slot_free;
    logic pop_ok;
    logic sweep_end;
  } sts_t;

  function automatic ctl_t ucode(step_t s);
    ctl_t w;
    w = '0;
    case (s)
      ST_SWEEP: begin
        w.cond = C_SWEEP_END; w.on_true = ST_IDLE; w.on_false = ST_SWEEP;
        w.sweep = 1'b1;
      end
      ST_IDLE: begin
        w.cond = C_ACCEPT; w.on_true = ST_IDLE; w.on_false = ST_IDLE;
        w.accept = 1'b1; w.stk_rd = 1'b1; w.ans_rd = 1'b1;
      end
      ST_CLR: begin
        w.cond = C_SLOT; w.on_true = ST_SWEEP; w.on_false = ST_CLR;
        w.cnt_clr = 1'b1; w.emit = RES_ZERO;
      end
      ST_NOP: begin
        w.cond = C_SLOT; w.on_true = ST_IDLE; w.on_false = ST_NOP;
        w.emit = RES_ZERO;
      end
      ST_QOUT: begin
        w.cond = C_SLOT; w.on_true = ST_IDLE; w.on_false = ST_QOUT;
        w.emit = RES_QUERY;
      end
      ST_PCMP: begin
        w.cond = C_POP; w.on_true = ST_PCMP; w.on_false = ST_PPUSH;
        w.pop = 1'b1; w.stk_rd = 1'b1;
      end
      ST_PPUSH: begin
        w.cond = C_SLOT; w.on_true = ST_IDLE; w.on_false = ST_PPUSH;
        w.push = 1'b1; w.emit = RES_PUSH;
      end
      default: begin
        w.cond = C_ALWAYS; w.on_true = ST_IDLE; w.on_false = ST_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic step_t dispatch(op_t op);
    step_t s;
    unique case (op)
      OP_CLEAR: s = ST_CLR;
      OP_PUSH:  s = ST_PCMP;
      OP_QUERY: s = ST_QOUT;
      OP_NONE:  s = ST_NOP;
      default:  s = ST_NOP;
    endcase
    return s;
  endfunction

  function automatic val_t val_from_io(io_val_t x);
    val_t r;
    r = '0;
    for (int i = 0; i < VB_MIN; i++) r[i] = x[i];
    return r;
  endfunction

  function automatic io_val_t io_from_val(val_t x);
    io_val_t r;
    r = '0;
    for (int i = 0; i < VB_MIN; i++) r[i] = x[i];
    return r;
  endfunction

endpackage

FILE: rtl/core/nge_if.sv
// nge_if: valid/ready channel interfaces for items in and results out.
// Depends on nge_pkg for field widths.
interface nge_in_if;
  import nge_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [IO_BITS-1:0]  value;
  modport source (output valid, operation, value, input ready);
  modport sink   (input valid, operation, value, output ready);
endinterface

interface nge_out_if;
  import nge_pkg::*;
  logic                valid;
  logic                ready;
  logic                found;
  logic [IO_BITS-1:0]  next_value;
  logic                overflow;
  modport source (output valid, found, next_value, overflow, input ready);
  modport sink   (input valid, found, next_value, overflow, output ready);
endinterface

FILE: rtl/core/nge_seq.sv
// nge_seq: step counter, microcode ROM lookup and jump condition logic.
// Depends on nge_pkg (ucode, dispatch, ctl_t, sts_t).
module nge_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [nge_pkg::OP_W-1:0] in_operation,
  input  nge_pkg::sts_t      sts,
  output nge_pkg::ctl_t      ctl
);
  import nge_pkg::*;

  step_t pc_r, pc_nxt;
  ctl_t  word;
  logic  cond_ok;

  assign word = ucode(pc_r);

  always_comb begin
    unique case (word.cond)
      C_ALWAYS:    cond_ok = 1'b1;
      C_ACCEPT:    cond_ok = in_valid;
      C_SLOT:      cond_ok = sts.slot_free;
      C_POP:       cond_ok = sts.pop_ok;
      C_SWEEP_END: cond_ok = sts.sweep_end;
      default:     cond_ok = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    if (word.cond == C_ACCEPT) begin
      pc_nxt = in_valid ? dispatch(op_t'(in_operation)) : ST_IDLE;
    end else begin
      pc_nxt = cond_ok ? word.on_true : word.on_false;
    end
  end

  // control outputs: slot and pop steps only act when their condition holds
  always_comb begin
    ctl = word;
    if ((word.cond == C_SLOT || word.cond == C_POP) && !cond_ok) begin
      ctl.pop     = 1'b0;
      ctl.push    = 1'b0;
      ctl.cnt_clr = 1'b0;
      ctl.stk_rd  = 1'b0;
      ctl.emit    = RES_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_SWEEP;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

FILE: rtl/core/nge_dp.sv
// nge_dp: datapath with stack memory, answer table memory, stack count,
// clearing sweep counter and result register. Depends on nge_pkg.
module nge_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  nge_pkg::ctl_t            ctl,
  input  logic                     in_valid,
  input  logic [nge_pkg::IO_BITS-1:0] in_value,
  input  logic                     out_ready,
  output nge_pkg::sts_t            sts,
  output logic                     out_valid,
  output logic                     out_found,
  output logic [nge_pkg::IO_BITS-1:0] out_next_value,
  output logic                     out_overflow
);
  import nge_pkg::*;

  val_t  stk_mem [STACK_DEPTH];
  ans_t  ans_mem [ANS_DEPTH];

  val_t  val_r;
  cnt_t  cnt_r;
  val_t  sweep_r;
  val_t  stk_q;
  ans_t  ans_q;

  logic    out_valid_r;
  logic    found_r;
  io_val_t next_r;
  logic    ovf_r;

  logic        full;
  logic        slot_free;
  cnt_t        rd_ptr;
  logic        ans_we;
  val_t        ans_wa;
  ans_t        ans_wd;

  assign full      = (cnt_r == cnt_t'(STACK_DEPTH));
  assign slot_free = !out_valid_r || out_ready;
  // when popping, fetch the entry below the one being removed
  assign rd_ptr    = ctl.pop ? (cnt_r - cnt_t'(2)) : (cnt_r - cnt_t'(1));

  assign sts.slot_free = slot_free;
  assign sts.pop_ok    = (cnt_r != '0) && (stk_q < val_r);
  assign sts.sweep_end = &sweep_r;

  assign ans_we = ctl.sweep || ctl.pop;
  assign ans_wa = ctl.sweep ? sweep_r : stk_q;
  assign ans_wd = ctl.sweep ? ans_t'(0) : {1'b1, val_r};

  always_ff @(posedge clk) begin
    if (ctl.push && !full) begin
      stk_mem[cnt_r[STK_AW-1:0]] <= val_r;
    end
    if (ctl.stk_rd) begin
      stk_q <= stk_mem[rd_ptr[STK_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ans_we) begin
      ans_mem[ans_wa] <= ans_wd;
    end
    if (ctl.ans_rd) begin
      ans_q <= ans_mem[val_from_io(in_value)];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept && in_valid) begin
      val_r <= val_from_io(in_value);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      sweep_r <= '0;
    end else begin
      if (ctl.cnt_clr) begin
        cnt_r <= '0;
      end else if (ctl.pop) begin
        cnt_r <= cnt_r - cnt_t'(1);
      end else if (ctl.push && !full) begin
        cnt_r <= cnt_r + cnt_t'(1);
      end
      if (ctl.sweep) begin
        sweep_r <= sweep_r + val_t'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit != RES_NONE) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.emit)
      RES_NONE: begin
      end
      RES_ZERO: begin
        found_r <= 1'b0;
        next_r  <= '0;
        ovf_r   <= 1'b0;
      end
      RES_QUERY: begin
        found_r <= ans_q[VALUE_BITS];
        next_r  <= ans_q[VALUE_BITS] ? io_from_val(ans_q[VALUE_BITS-1:0]) : io_val_t'(0);
        ovf_r   <= 1'b0;
      end
      RES_PUSH: begin
        found_r <= 1'b0;
        next_r  <= '0;
        ovf_r   <= full;
      end
      default: begin
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_found      = found_r;
  assign out_next_value = next_r;
  assign out_overflow   = ovf_r;

endmodule

FILE: rtl/core/next_greater_element_engine.sv
// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    operation[1:0], value[9:0]
// out_ch    out  valid/ready    found, next_value[9:0], overflow
//
// Push: the compare step pops each smaller top entry, then the push step stores the value.
// Query: answer table read, then result. Op code 3 gives an all-zero result.
// Clear: the stack count is reset, then the answer table is swept one entry a cycle.
// After reset the same sweep runs with in_ready low.
// A waiting result stalls the sequencer only when the next result is due.
//
// Top level: sequencer plus datapath. Depends on nge_pkg, nge_if, nge_seq, nge_dp.
module next_greater_element_engine (
  input logic       clk,
  input logic       rst_n,
  nge_in_if.sink    in_ch,
  nge_out_if.source out_ch
);
  import nge_pkg::*;

  ctl_t ctl;
  sts_t sts;

  assign in_ch.ready = ctl.accept;

  nge_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_operation (in_ch.operation),
    .sts          (sts),
    .ctl          (ctl)
  );

  nge_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .in_valid       (in_ch.valid),
    .in_value       (in_ch.value),
    .out_ready      (out_ch.ready),
    .sts            (sts),
    .out_valid      (out_ch.valid),
    .out_found      (out_ch.found),
    .out_next_value (out_ch.next_value),
    .out_overflow   (out_ch.overflow)
  );

endmodule

FILE: rtl/core/nge_chk.sv
// nge_chk: port-level checks on the result channel, bound to the top level.
// Depends on nge_pkg.
module nge_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_found,
  input logic [nge_pkg::IO_BITS-1:0] out_next_value,
  input logic                       out_overflow
);
  import nge_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_next_value) && $stable(out_found)
                                && $stable(out_overflow))
    else $error("stalled result changed");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_next_value == '0)
    else $error("next_value nonzero without found");

  a_kind_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> !out_found)
    else $error("overflow and found in one result");

endmodule

bind next_greater_element_engine nge_chk u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_found      (out_ch.found),
  .out_next_value (out_ch.next_value),
  .out_overflow   (out_ch.overflow)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for next_greater_element_engine; needs nge_pkg and
// the nge_in_if / nge_out_if channels. A local monotonic stack and answer table
// predict every result, which is checked field by field in transfer order.
module tb_top;
  import nge_pkg::*;

  localparam int IDLE_PCT     = 15;
  localparam int STALL_LIMIT  = 4000;  // the clear sweep of the answer table has no transfer
  localparam int DRAIN_CYCLES = 100;
  localparam int MAX_REPORTS  = 50;

  typedef struct packed {
    logic    found;
    io_val_t next_value;
    logic    overflow;
  } nge_result_t;

  typedef enum int {
    RUN_UNIFORM,
    RUN_NARROW,
    RUN_FALLING,
    RUN_EXTREME,
    RUN_PLATEAU
  } run_style_t;

  logic clk;
  logic rst_n;

  nge_in_if  in_ch ();
  nge_out_if out_ch ();

  next_greater_element_engine dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // local copy of the engine state
  val_t        stk_mem       [STACK_DEPTH];
  int          stk_depth;
  val_t        nge_answer    [ANS_DEPTH];
  bit          nge_known     [ANS_DEPTH];
  bit          ever_recorded [ANS_DEPTH];
  int          live_answers[$];  // values answered in the current sequence
  int          past_answers[$];  // values whose table entry has been written
  nge_result_t pending_results[$];

  bit no_gaps;
  int errors, quiet_cycles, n_items, n_push, n_query, n_found, n_overflow;
  int n_clear, n_noop, n_results, max_pops;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic nge_result_t predict_next_greater(op_t op, io_val_t raw);
    nge_result_t r;
    val_t        v;
    val_t        top;
    int          pops;
    r    = '0;
    v    = val_t'(raw);
    pops = 0;
    case (op)
      OP_CLEAR: begin
        stk_depth = 0;
        foreach (nge_known[i]) nge_known[i] = 1'b0;
        live_answers.delete();
        n_clear++;
      end
      OP_PUSH: begin
        while (stk_depth > 0 && stk_mem[stk_depth-1] < v) begin
          top = stk_mem[stk_depth-1];
          if (!nge_known[top]) live_answers = {live_answers, int'(top)};
          if (!ever_recorded[top]) past_answers = {past_answers, int'(top)};
          nge_known[top]     = 1'b1;
          ever_recorded[top] = 1'b1;
          nge_answer[top]    = v;
          stk_depth--;
          pops++;
        end
        if (stk_depth >= STACK_DEPTH) begin
          r.overflow = 1'b1;
          n_overflow++;
        end else begin
          stk_mem[stk_depth] = v;
          stk_depth++;
        end
        n_push++;
      end
      OP_QUERY: begin
        if (nge_known[v]) begin
          r.found      = 1'b1;
          r.next_value = io_val_t'(nge_answer[v]);
          n_found++;
        end
        n_query++;
      end
      OP_NONE: n_noop++;
    endcase
    if (pops > max_pops) max_pops = pops;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("tb_top: mismatch on %s at result %0d: got %0d, expected %0d",
               what, n_results, got, want);
  endtask

  task automatic send_item(op_t op, io_val_t v);
    while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.value     <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results = {pending_results, predict_next_greater(op, v)};
    n_items++;
  endtask

  // result side: random back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : check_results
    nge_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      n_results++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.found !== want.found)
          report_mismatch("found", int'(out_ch.found), int'(want.found));
        if (out_ch.next_value !== want.next_value)
          report_mismatch("next_value", int'(out_ch.next_value), int'(want.next_value));
        if (out_ch.overflow !== want.overflow)
          report_mismatch("overflow", int'(out_ch.overflow), int'(want.overflow));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top: no transfer for %0d cycles, %0d results still pending",
               quiet_cycles, pending_results.size());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic test_directed_ops();
    send_item(OP_PUSH, 10'd5);
    send_item(OP_PUSH, 10'd3);
    send_item(OP_PUSH, 10'd3);     // equal value stays stacked
    send_item(OP_PUSH, 10'd1023);  // pops 3, 3 and 5
    send_item(OP_PUSH, 10'd0);
    send_item(OP_PUSH, 10'd1023);  // pops 0, equal 1023 stays
    send_item(OP_PUSH, 10'd1022);
    send_item(OP_QUERY, 10'd3);
    send_item(OP_QUERY, 10'd5);
    send_item(OP_QUERY, 10'd0);
    send_item(OP_NONE, io_val_t'($urandom));
    send_item(OP_QUERY, 10'd0);    // unused code must not disturb state
    send_item(OP_CLEAR, io_val_t'($urandom));
    send_item(OP_QUERY, 10'd3);    // answered before the clear only
    send_item(OP_PUSH, 10'd2);
    send_item(OP_PUSH, 10'd7);
    send_item(OP_PUSH, 10'd2);
    send_item(OP_PUSH, 10'd9);     // 2 gets a second answer, last one wins
    send_item(OP_QUERY, 10'd2);
    send_item(OP_QUERY, 10'd7);
    send_item(OP_QUERY, 10'd5);
  endtask

  task automatic test_stack_overflow();
    val_t level;
    send_item(OP_CLEAR, '0);
    level = 10'd1000;
    // non-increasing run never pops, so the tail of it is dropped
    repeat (STACK_DEPTH + 6) begin
      send_item(OP_PUSH, io_val_t'(level));
      if ($urandom_range(3) == 0) level--;
    end
    send_item(OP_PUSH, io_val_t'(level + 10'd1));  // pops some of a full stack
    send_item(OP_PUSH, 10'd1023);                 // drains the whole stack
    send_item(OP_QUERY, 10'd1000);
    send_item(OP_QUERY, io_val_t'(level));
  endtask

  task automatic test_random_sequences(int count, bit calm);
    int         target, seq_len, roll, lo;
    run_style_t style;
    io_val_t    v, q_val;
    no_gaps = calm;
    target  = n_items - n_noop + count;
    while (n_items - n_noop < target) begin
      if ($urandom_range(99) < 85) send_item(OP_CLEAR, io_val_t'($urandom));
      style   = run_style_t'($urandom_range(4));
      seq_len = (style == RUN_PLATEAU) ? 2 * STACK_DEPTH : $urandom_range(48, 4);
      lo      = $urandom_range(1015, 0);
      v       = io_val_t'($urandom);
      repeat (seq_len) begin
        roll = $urandom_range(99);
        if (roll < 4) begin
          send_item(OP_NONE, io_val_t'($urandom));
        end else if (roll < 30) begin
          // mostly values with an answer on record, now and then any value
          if (live_answers.size() > 0 && $urandom_range(3) != 0)
            q_val = io_val_t'(live_answers[$urandom_range(live_answers.size() - 1, 0)]);
          else if (past_answers.size() > 0 && $urandom_range(1) == 0)
            q_val = io_val_t'(past_answers[$urandom_range(past_answers.size() - 1, 0)]);
          else
            q_val = io_val_t'($urandom);
          send_item(OP_QUERY, q_val);
        end else begin
          case (style)
            RUN_UNIFORM: v = io_val_t'($urandom);
            RUN_NARROW:  v = io_val_t'($urandom_range(lo + 8, lo));
            RUN_FALLING: begin
              if ($urandom_range(5) == 0) v = io_val_t'($urandom);
              else v = v - io_val_t'($urandom_range(40, 0));
            end
            RUN_EXTREME: begin
              case ($urandom_range(2))
                0:       v = '0;
                1:       v = '1;
                default: v = io_val_t'($urandom);
              endcase
            end
            RUN_PLATEAU: if (v > 0 && $urandom_range(1) == 1) v = v - 1'b1;
          endcase
          send_item(OP_PUSH, v);
        end
      end
    end
  endtask

  initial begin
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_NONE;
    in_ch.value     <= '0;
    rst_n           <= 1'b0;
    no_gaps         = 1'b0;
    stk_depth       = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_ops();
    test_stack_overflow();
    test_random_sequences(350, 1'b0);
    test_random_sequences(200, 1'b1);
    test_random_sequences(300, 1'b0);
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb_top: sent %0d items: %0d pushes, %0d queries, %0d clears, %0d unused codes",
             n_items, n_push, n_query, n_clear, n_noop);
    $display("tb_top: %0d results checked, %0d answers found, %0d dropped pushes, %0d max pops",
             n_results, n_found, n_overflow, max_pops);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
